// ===== rtl/terminal_key_decoder_line_editor_core_assert.svh =====
// assertion macros used by the checker file tkd_checker
`ifndef TERMINAL_KEY_DECODER_LINE_EDITOR_CORE_ASSERT_SVH
`define TERMINAL_KEY_DECODER_LINE_EDITOR_CORE_ASSERT_SVH

// condition must hold in the same cycle
`define TKD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition must hold in the following cycle
`define TKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tkd_pkg.sv =====
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared constants, event codes and cell control type for the key decoder
// and line editor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkd_pkg;

  // sizes
  localparam int LINE_BYTES = 64;
  localparam int ESC_BYTES  = 32;
  localparam int POS_W      = 6;
  localparam int CNT_W      = 5;

  // event codes
  localparam logic [4:0] EV_PENDING      = 5'd0;
  localparam logic [4:0] EV_INSERT       = 5'd1;
  localparam logic [4:0] EV_FULL_DROP    = 5'd2;
  localparam logic [4:0] EV_LEFT         = 5'd3;
  localparam logic [4:0] EV_RIGHT        = 5'd4;
  localparam logic [4:0] EV_UP           = 5'd5;
  localparam logic [4:0] EV_DOWN         = 5'd6;
  localparam logic [4:0] EV_DEL          = 5'd7;
  localparam logic [4:0] EV_BKSP         = 5'd8;
  localparam logic [4:0] EV_HOME         = 5'd9;
  localparam logic [4:0] EV_END          = 5'd10;
  localparam logic [4:0] EV_CANCEL       = 5'd11;
  localparam logic [4:0] EV_LINE_BYTE    = 5'd12;
  localparam logic [4:0] EV_LINE_DONE    = 5'd13;
  localparam logic [4:0] EV_UNKNOWN      = 5'd14;
  localparam logic [4:0] EV_BAD_ESC      = 5'd15;
  localparam logic [4:0] EV_NON_CSI      = 5'd16;
  localparam logic [4:0] EV_UNKNOWN_CSI  = 5'd17;
  localparam logic [4:0] EV_ESC_OVERFLOW = 5'd18;

  // escape parser phases
  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_ESC    = 2'd1;
  localparam logic [1:0] PH_CSI    = 2'd2;
  localparam logic [1:0] PH_INTER  = 2'd3;

  // cell operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_DELETE = 2'd2;
  localparam logic [1:0] CELL_SHIFT  = 2'd3;

  // byte values
  localparam logic [7:0] CH_CTRL_A  = 8'h01;
  localparam logic [7:0] CH_CTRL_C  = 8'h03;
  localparam logic [7:0] CH_CTRL_E  = 8'h05;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_ESC     = 8'd27;
  localparam logic [7:0] CH_LBRACK  = 8'h5b;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_3       = 8'h33;
  localparam logic [7:0] CH_TILDE   = 8'd126;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_INT_END = 8'h2f;
  localparam logic [7:0] CH_FIN_LO  = 8'h40;
  localparam logic [7:0] CH_ESC_HI  = 8'h5f;
  localparam logic [7:0] CH_PRN_HI  = 8'h7e;

  // control broadcast to every cell of the line row
  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] len;
    logic [7:0]       fill;
  } cell_ctl_t;

endpackage

// ===== rtl/tkd_cell.sv =====
// ----------------------------------------------------------------------------
// tkd_cell
// One character slot of the line store. On insert takes the fill byte at the
// insert position, else the left neighbor's; the right neighbor's on delete or readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkd_cell (
  input  logic                     clk,
  input  tkd_pkg::cell_ctl_t       ctl,
  input  logic [tkd_pkg::POS_W-1:0] idx,
  input  logic [7:0]               left_data,
  input  logic [7:0]               right_data,
  output logic [7:0]               data
);

  logic [tkd_pkg::POS_W:0] idx_x;
  logic [tkd_pkg::POS_W:0] pos_x;
  logic [tkd_pkg::POS_W:0] len_x;
  logic [7:0]              data_next;

  assign idx_x = {1'b0, idx};
  assign pos_x = {1'b0, ctl.pos};
  assign len_x = {1'b0, ctl.len};

  // slot update by operation and position
  always_comb begin
    data_next = data;
    case (ctl.op)
      tkd_pkg::CELL_INSERT: begin
        if (idx_x == pos_x) begin
          data_next = ctl.fill;
        end else if (idx_x > pos_x && idx_x <= len_x) begin
          data_next = left_data;
        end
      end
      tkd_pkg::CELL_DELETE: begin
        if (idx_x >= pos_x && (idx_x + 1'b1) < len_x) begin
          data_next = right_data;
        end
      end
      tkd_pkg::CELL_SHIFT: data_next = right_data;
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== rtl/tkd_row.sv =====
// ----------------------------------------------------------------------------
// tkd_row
// Row of line store cells, each linked to its neighbors. Slot zero is
// the head that readout drains from.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkd_row (
  input  logic               clk,
  input  tkd_pkg::cell_ctl_t ctl,
  output logic [7:0]         head
);

  logic [7:0] slot [tkd_pkg::LINE_BYTES];

  genvar i;
  generate
    for (i = 0; i < tkd_pkg::LINE_BYTES; i++) begin : g_cell
      logic [7:0] from_left;
      logic [7:0] from_right;

      // edge cells see zero outside the row
      if (i == 0) begin : g_first
        assign from_left = 8'h00;
      end else begin : g_mid_l
        assign from_left = slot[i-1];
      end
      if (i == tkd_pkg::LINE_BYTES - 1) begin : g_last
        assign from_right = 8'h00;
      end else begin : g_mid_r
        assign from_right = slot[i+1];
      end

      tkd_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .idx        (tkd_pkg::POS_W'(i)),
        .left_data  (from_left),
        .right_data (from_right),
        .data       (slot[i])
      );
    end
  endgenerate

  assign head = slot[0];

endmodule

// ===== rtl/terminal_key_decoder_line_editor_core.sv =====
// Results: a byte other than CR or LF gives a single result, registered in the cycle after the byte is accepted.
// Throughput: one byte per cycle for edit, cursor and escape bytes unless a readout
// runs or the result stalls; inserts and deletes shift the cells past the position at once.
// Enter drains the row one cell per cycle unless the result stalls: length+1 results.
// Reset: synchronous; clears parser, cursor, length and output valid; cells are not reset.
// ----------------------------------------------------------------------------
// terminal_key_decoder_line_editor_core
// Terminal key decoder with ESC/CSI parser and a bounded line editor built
// on a row of character cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module terminal_key_decoder_line_editor_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rx_valid,
  output logic                      rx_stall,
  input  logic [7:0]                rx_byte,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [4:0]                event_res,
  output logic [7:0]                line_byte,
  output logic [tkd_pkg::POS_W-1:0] cursor,
  output logic [tkd_pkg::POS_W-1:0] length,
  output logic                      last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;
  localparam logic [tkd_pkg::CNT_W-1:0] ESC_MAX = tkd_pkg::CNT_W'(tkd_pkg::ESC_BYTES - 1);
  localparam logic [tkd_pkg::POS_W-1:0] LEN_MAX = tkd_pkg::POS_W'(tkd_pkg::LINE_BYTES - 1);

  logic                      state;
  logic [1:0]                phase;
  logic [7:0]                seq_first;
  logic [7:0]                seq_second;
  logic [tkd_pkg::CNT_W-1:0] seq_count;
  logic [tkd_pkg::POS_W-1:0] line_length;
  logic [tkd_pkg::POS_W-1:0] cursor_pos;
  logic [tkd_pkg::POS_W-1:0] sent;

  logic [1:0]                phase_next;
  logic [7:0]                first_next;
  logic [7:0]                second_next;
  logic [tkd_pkg::CNT_W-1:0] count_next;
  logic [tkd_pkg::POS_W-1:0] len_next;
  logic [tkd_pkg::POS_W-1:0] cur_next;
  logic [4:0]                ev;
  logic                      go_emit;
  tkd_pkg::cell_ctl_t        dec_ctl;
  tkd_pkg::cell_ctl_t        row_ctl;
  logic [7:0]                head;

  logic                      out_free;
  logic                      accept;
  logic                      emit_step;
  logic                      emit_byte;

  // pushed sequence bytes and finish decode
  logic                      cnt_sat;
  logic [7:0]                first_p;
  logic [7:0]                second_p;
  logic [tkd_pkg::CNT_W-1:0] count_p;
  logic [7:0]                sec_f;
  logic [4:0]                fin_ev;
  logic [tkd_pkg::POS_W-1:0] fin_cur;
  logic [tkd_pkg::POS_W-1:0] fin_len;
  tkd_pkg::cell_ctl_t        fin_ctl;
  tkd_pkg::cell_ctl_t        hold_ctl;

  // handshake
  assign out_free  = !res_valid || !res_stall;
  assign rx_stall  = (state != ST_IDLE) || !out_free;
  assign accept    = rx_valid && !rx_stall;
  assign emit_step = (state == ST_EMIT) && out_free;
  assign emit_byte = sent < line_length;

  assign hold_ctl = '{op: tkd_pkg::CELL_HOLD, pos: cursor_pos, len: line_length, fill: rx_byte};

  // sequence byte capture, saturating count
  always_comb begin
    cnt_sat  = seq_count >= ESC_MAX;
    first_p  = (!cnt_sat && seq_count == '0) ? rx_byte : seq_first;
    second_p = (!cnt_sat && seq_count == tkd_pkg::CNT_W'(1)) ? rx_byte : seq_second;
    count_p  = cnt_sat ? seq_count : seq_count + 1'b1;
    sec_f    = (count_p >= tkd_pkg::CNT_W'(2)) ? second_p : 8'h00;
  end

  // final byte of a csi sequence
  always_comb begin
    fin_ev  = tkd_pkg::EV_UNKNOWN_CSI;
    fin_cur = cursor_pos;
    fin_len = line_length;
    fin_ctl = hold_ctl;
    if (count_p >= ESC_MAX) begin
      fin_ev = tkd_pkg::EV_ESC_OVERFLOW;
    end else if (first_p == tkd_pkg::CH_D) begin
      fin_ev = tkd_pkg::EV_LEFT;
      if (cursor_pos != '0) fin_cur = cursor_pos - 1'b1;
    end else if (first_p == tkd_pkg::CH_C) begin
      fin_ev = tkd_pkg::EV_RIGHT;
      if (cursor_pos < line_length) fin_cur = cursor_pos + 1'b1;
    end else if (first_p == tkd_pkg::CH_A) begin
      fin_ev = tkd_pkg::EV_UP;
    end else if (first_p == tkd_pkg::CH_B) begin
      fin_ev = tkd_pkg::EV_DOWN;
    end else if (first_p == tkd_pkg::CH_3 && sec_f == tkd_pkg::CH_TILDE) begin
      fin_ev = tkd_pkg::EV_DEL;
      if (cursor_pos < line_length) begin
        fin_len    = line_length - 1'b1;
        fin_ctl.op = tkd_pkg::CELL_DELETE;
      end
    end
  end

  // byte decode
  always_comb begin
    phase_next  = phase;
    first_next  = seq_first;
    second_next = seq_second;
    count_next  = seq_count;
    len_next    = line_length;
    cur_next    = cursor_pos;
    ev          = tkd_pkg::EV_PENDING;
    go_emit     = 1'b0;
    dec_ctl     = hold_ctl;
    if (phase == tkd_pkg::PH_ESC && rx_byte inside {[tkd_pkg::CH_FIN_LO:tkd_pkg::CH_ESC_HI]}) begin
      if (rx_byte == tkd_pkg::CH_LBRACK) begin
        phase_next = tkd_pkg::PH_CSI;
      end else begin
        phase_next = tkd_pkg::PH_NORMAL;
        ev         = tkd_pkg::EV_NON_CSI;
      end
    end else if (phase == tkd_pkg::PH_CSI) begin
      if (!(rx_byte inside {[tkd_pkg::CH_SPACE:tkd_pkg::CH_PRN_HI]})) begin
        phase_next = tkd_pkg::PH_NORMAL;
        count_next = '0;
        ev         = tkd_pkg::EV_BAD_ESC;
      end else begin
        first_next  = first_p;
        second_next = second_p;
        if (rx_byte >= tkd_pkg::CH_FIN_LO) begin
          phase_next = tkd_pkg::PH_NORMAL;
          count_next = '0;
          ev         = fin_ev;
          cur_next   = fin_cur;
          len_next   = fin_len;
          dec_ctl    = fin_ctl;
        end else begin
          count_next = count_p;
          if (rx_byte <= tkd_pkg::CH_INT_END) phase_next = tkd_pkg::PH_INTER;
        end
      end
    end else if (phase == tkd_pkg::PH_INTER) begin
      if (rx_byte inside {[tkd_pkg::CH_FIN_LO:tkd_pkg::CH_PRN_HI]}) begin
        first_next  = first_p;
        second_next = second_p;
        phase_next  = tkd_pkg::PH_NORMAL;
        count_next  = '0;
        ev          = fin_ev;
        cur_next    = fin_cur;
        len_next    = fin_len;
        dec_ctl     = fin_ctl;
      end else if (rx_byte inside {[tkd_pkg::CH_SPACE:tkd_pkg::CH_INT_END]}) begin
        first_next  = first_p;
        second_next = second_p;
        count_next  = count_p;
      end else begin
        phase_next = tkd_pkg::PH_NORMAL;
        count_next = '0;
        ev         = tkd_pkg::EV_BAD_ESC;
      end
    end else begin
      // plain byte, also after esc when outside the escape range
      case (rx_byte)
        tkd_pkg::CH_CR, tkd_pkg::CH_LF: go_emit = 1'b1;
        tkd_pkg::CH_CTRL_A: begin
          cur_next = '0;
          ev       = tkd_pkg::EV_HOME;
        end
        tkd_pkg::CH_CTRL_C: begin
          cur_next = '0;
          len_next = '0;
          ev       = tkd_pkg::EV_CANCEL;
        end
        tkd_pkg::CH_CTRL_E: begin
          cur_next = line_length;
          ev       = tkd_pkg::EV_END;
        end
        tkd_pkg::CH_BS: begin
          ev = tkd_pkg::EV_BKSP;
          if (cursor_pos != '0) begin
            cur_next    = cursor_pos - 1'b1;
            len_next    = line_length - 1'b1;
            dec_ctl.op  = tkd_pkg::CELL_DELETE;
            dec_ctl.pos = cursor_pos - 1'b1;
          end
        end
        tkd_pkg::CH_ESC: phase_next = tkd_pkg::PH_ESC;
        default: begin
          if (rx_byte inside {[tkd_pkg::CH_SPACE:tkd_pkg::CH_PRN_HI]}) begin
            if (line_length >= LEN_MAX) begin
              ev = tkd_pkg::EV_FULL_DROP;
            end else begin
              ev         = tkd_pkg::EV_INSERT;
              cur_next   = cursor_pos + 1'b1;
              len_next   = line_length + 1'b1;
              dec_ctl.op = tkd_pkg::CELL_INSERT;
            end
          end else begin
            ev = tkd_pkg::EV_UNKNOWN;
          end
        end
      endcase
    end
  end

  // cell row control: readout shift, edit on accept, else hold
  always_comb begin
    row_ctl = hold_ctl;
    if (emit_step && emit_byte) begin
      row_ctl.op = tkd_pkg::CELL_SHIFT;
    end else if (accept) begin
      row_ctl = dec_ctl;
    end
  end

  tkd_row u_row (
    .clk  (clk),
    .ctl  (row_ctl),
    .head (head)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= tkd_pkg::PH_NORMAL;
      seq_first   <= '0;
      seq_second  <= '0;
      seq_count   <= '0;
      line_length <= '0;
      cursor_pos  <= '0;
      sent        <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      seq_first  <= first_next;
      seq_second <= second_next;
      seq_count  <= count_next;
      if (go_emit) begin
        state <= ST_EMIT;
        sent  <= '0;
      end else begin
        line_length <= len_next;
        cursor_pos  <= cur_next;
      end
    end else if (emit_step) begin
      if (emit_byte) begin
        sent <= sent + 1'b1;
      end else begin
        state       <= ST_IDLE;
        line_length <= '0;
        cursor_pos  <= '0;
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((accept && !go_emit) || emit_step) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && !go_emit) begin
      event_res <= ev;
      line_byte <= 8'h00;
      cursor    <= cur_next;
      length    <= len_next;
      last      <= 1'b1;
    end else if (emit_step) begin
      cursor <= cursor_pos;
      length <= line_length;
      if (emit_byte) begin
        event_res <= tkd_pkg::EV_LINE_BYTE;
        line_byte <= head;
        last      <= 1'b0;
      end else begin
        event_res <= tkd_pkg::EV_LINE_DONE;
        line_byte <= 8'h00;
        last      <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tkd_checker.sv =====
// ----------------------------------------------------------------------------
// tkd_checker
// Port level checks on the result stream of the key decoder core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "terminal_key_decoder_line_editor_core_assert.svh"

module tkd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_stall,
  input logic [4:0]                event_res,
  input logic [7:0]                line_byte,
  input logic [tkd_pkg::POS_W-1:0] cursor,
  input logic [tkd_pkg::POS_W-1:0] length,
  input logic                      last
);

  // only line bytes carry a character
  `TKD_ASSERT_NOW(a_byte_zero, res_valid && event_res != tkd_pkg::EV_LINE_BYTE, line_byte == 8'h00, "line_byte set on non-line word")

  // cursor never passes the line end
  `TKD_ASSERT_NOW(a_cursor_in_line, res_valid, cursor <= length, "cursor beyond line length")

  // line bytes are never last, line done always is
  `TKD_ASSERT_NOW(a_last_mark, res_valid && (event_res == tkd_pkg::EV_LINE_BYTE || event_res == tkd_pkg::EV_LINE_DONE), last == (event_res == tkd_pkg::EV_LINE_DONE), "wrong last flag on line readout")

  // a held word keeps its event
  `TKD_ASSERT_NEXT(a_hold_event, res_valid && res_stall, res_valid && $stable(event_res), "stalled word changed")

endmodule

bind terminal_key_decoder_line_editor_core tkd_checker u_tkd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .event_res (event_res),
  .line_byte (line_byte),
  .cursor    (cursor),
  .length    (length),
  .last      (last)
);
